// ===== sv/nntf_pkg.sv =====
// Shared types, constants and control structs for the nearest neighbor track filter.
package nntf_pkg;

    localparam int          MAX_TRACKS_DEF  = 64;
    localparam int          COORD_W         = 24;
    localparam int          GATE_W          = 23;
    localparam int          HITS_W          = 8;
    localparam int          MISS_W          = 17;
    localparam int          ALLOW_W         = 16;
    localparam int          CFG_IDX_W       = 2;
    localparam int          DIST_W          = 49;
    localparam int          GATE2_W         = 46;
    localparam logic [MISS_W-1:0] MISS_SAT  = '1;

    localparam logic [GATE_W-1:0]  GATE_RST   = 23'd256;
    localparam logic [HITS_W-1:0]  HITS_RST   = 8'd3;
    localparam logic [ALLOW_W-1:0] ALLOW_RST  = 16'd5;

    localparam logic [CFG_IDX_W-1:0] REG_GATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALLOW = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] east;
        logic signed [COORD_W-1:0] north;
        logic signed [COORD_W-1:0] cell_x;
        logic signed [COORD_W-1:0] cell_y;
        logic [HITS_W-1:0]         hits;
        logic [MISS_W-1:0]         misses;
        logic                      confirmed;
        logic                      matched;
    } t_trk;

    typedef enum logic [1:0] {
        DS_ENT_EAST,
        DS_ENT_NORTH,
        DS_PT_EAST,
        DS_PT_NORTH
    } t_div_src;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISP,
        ST_FS_RD,
        ST_FS_E,
        ST_FS_EW,
        ST_FS_N,
        ST_FS_NW,
        ST_FS_WR,
        ST_PT_E,
        ST_PT_EW,
        ST_PT_N,
        ST_PT_NW,
        ST_SC_INIT,
        ST_SC_RD,
        ST_SC_EV,
        ST_SC_SQ,
        ST_SC_CMP,
        ST_SC_COMMIT,
        ST_PT_END,
        ST_CP_RD,
        ST_CP_EV,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic     latch_in;
        logic     clr_tbl;
        logic     open_set;
        logic     sweep_clr;
        logic     idx_inc;
        logic     mem_rd;
        logic     div_start;
        logic     div_cap;
        t_div_src div_src;
        logic     fs_wr;
        logic     best_clr;
        logic     ev;
        logic     sq;
        logic     cmp;
        logic     commit;
        logic     cp_do;
        logic     emit_final;
    } t_cmd;

    typedef struct packed {
        logic idx_lt;
        logic div_done;
        logic open;
        logic mode;
        logic pval;
        logic flast;
        logic out_free;
        logic cp_need_push;
    } t_sts;

endpackage

// ===== sv/nntf_fdiv.sv =====
// Floor division of a signed coordinate by the gate, one quotient bit per cycle.
module nntf_fdiv (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic signed [nntf_pkg::COORD_W-1:0] i_dividend,
    input  logic [nntf_pkg::GATE_W-1:0]    i_divisor,
    output logic                           o_done,
    output logic signed [nntf_pkg::COORD_W-1:0] o_quo
);
    import nntf_pkg::*;

    localparam int CNT_W = $clog2(COORD_W);

    logic                r_busy, n_busy;
    logic                r_fin, n_fin;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [GATE_W-1:0]   r_rem;
    logic [COORD_W-1:0]  r_sh;
    logic [GATE_W-1:0]   r_div;
    logic                r_neg;
    logic signed [COORD_W-1:0] r_quo;

    logic [COORD_W-1:0]  w_trial;
    logic                w_ge;
    logic [COORD_W-1:0]  w_diff;

    assign w_trial = {r_rem, r_sh[COORD_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_fin  = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
        end else if (r_busy && r_cnt == CNT_W'(COORD_W - 1)) begin
            n_busy = 1'b0;
            n_fin  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_fin  <= n_fin;
            r_done <= r_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[COORD_W-1];
            r_sh  <= i_dividend[COORD_W-1] ? (COORD_W'(0) - i_dividend) : i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[GATE_W-1:0] : w_trial[GATE_W-1:0];
            r_sh  <= {r_sh[COORD_W-2:0], w_ge};
            r_cnt <= r_cnt + 1'b1;
        end
        if (r_fin) begin
            // round toward minus infinity when the remainder is nonzero
            r_quo <= r_neg ? (COORD_W'(0) - r_sh - COORD_W'(|r_rem)) : r_sh;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== sv/nntf_ctrl.sv =====
// Sequencer for table clear, frame start, point association and frame end compaction.
module nntf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  nntf_pkg::t_sts   i_sts,
    output nntf_pkg::t_cmd   o_cmd
);
    import nntf_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:      if (i_in_valid) n_state = ST_DISP;
            ST_DISP: begin
                if (i_sts.mode)       n_state = ST_IDLE;
                else if (!i_sts.open) n_state = ST_FS_RD;
                else                  n_state = ST_PT_E;
            end
            ST_FS_RD:     n_state = i_sts.idx_lt ? ST_FS_E : ST_PT_E;
            ST_FS_E:      n_state = ST_FS_EW;
            ST_FS_EW:     if (i_sts.div_done) n_state = ST_FS_N;
            ST_FS_N:      n_state = ST_FS_NW;
            ST_FS_NW:     if (i_sts.div_done) n_state = ST_FS_WR;
            ST_FS_WR:     n_state = ST_FS_RD;
            ST_PT_E:      n_state = i_sts.pval ? ST_PT_EW : ST_PT_END;
            ST_PT_EW:     if (i_sts.div_done) n_state = ST_PT_N;
            ST_PT_N:      n_state = ST_PT_NW;
            ST_PT_NW:     if (i_sts.div_done) n_state = ST_SC_INIT;
            ST_SC_INIT:   n_state = ST_SC_RD;
            ST_SC_RD:     n_state = i_sts.idx_lt ? ST_SC_EV : ST_SC_COMMIT;
            ST_SC_EV:     n_state = ST_SC_SQ;
            ST_SC_SQ:     n_state = ST_SC_CMP;
            ST_SC_CMP:    n_state = ST_SC_RD;
            ST_SC_COMMIT: n_state = ST_PT_END;
            ST_PT_END:    n_state = i_sts.flast ? ST_CP_RD : ST_IDLE;
            ST_CP_RD:     n_state = i_sts.idx_lt ? ST_CP_EV : ST_FIN;
            ST_CP_EV: begin
                if (!(i_sts.cp_need_push && !i_sts.out_free)) n_state = ST_CP_RD;
            end
            ST_FIN:       if (i_sts.out_free) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.latch_in = i_in_valid;
            end
            ST_DISP: begin
                o_cmd.clr_tbl   = i_sts.mode;
                o_cmd.sweep_clr = !i_sts.mode && !i_sts.open;
            end
            ST_FS_RD: begin
                o_cmd.mem_rd   = i_sts.idx_lt;
                o_cmd.open_set = !i_sts.idx_lt;
            end
            ST_FS_E: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_src   = DS_ENT_EAST;
            end
            ST_FS_EW: begin
                o_cmd.div_cap = i_sts.div_done;
                o_cmd.div_src = DS_ENT_EAST;
            end
            ST_FS_N: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_src   = DS_ENT_NORTH;
            end
            ST_FS_NW: begin
                o_cmd.div_cap = i_sts.div_done;
                o_cmd.div_src = DS_ENT_NORTH;
            end
            ST_FS_WR: begin
                o_cmd.fs_wr   = 1'b1;
                o_cmd.idx_inc = 1'b1;
            end
            ST_PT_E: begin
                o_cmd.div_start = i_sts.pval;
                o_cmd.div_src   = DS_PT_EAST;
            end
            ST_PT_EW: begin
                o_cmd.div_cap = i_sts.div_done;
                o_cmd.div_src = DS_PT_EAST;
            end
            ST_PT_N: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_src   = DS_PT_NORTH;
            end
            ST_PT_NW: begin
                o_cmd.div_cap = i_sts.div_done;
                o_cmd.div_src = DS_PT_NORTH;
            end
            ST_SC_INIT: begin
                o_cmd.best_clr  = 1'b1;
                o_cmd.sweep_clr = 1'b1;
            end
            ST_SC_RD:     o_cmd.mem_rd = i_sts.idx_lt;
            ST_SC_EV:     o_cmd.ev     = 1'b1;
            ST_SC_SQ:     o_cmd.sq     = 1'b1;
            ST_SC_CMP: begin
                o_cmd.cmp     = 1'b1;
                o_cmd.idx_inc = 1'b1;
            end
            ST_SC_COMMIT: o_cmd.commit = 1'b1;
            ST_PT_END:    o_cmd.sweep_clr = i_sts.flast;
            ST_CP_RD:     o_cmd.mem_rd = i_sts.idx_lt;
            ST_CP_EV: begin
                // hold while the previous word cannot leave yet
                if (!(i_sts.cp_need_push && !i_sts.out_free)) begin
                    o_cmd.cp_do   = 1'b1;
                    o_cmd.idx_inc = 1'b1;
                end
            end
            ST_FIN:       o_cmd.emit_final = i_sts.out_free;
            default:      o_cmd = '0;
        endcase
    end

endmodule

// ===== sv/nntf_dp.sv =====
// Track table, distance scan, compaction and output register.
module nntf_dp #(
    parameter int MAX_TRACKS = nntf_pkg::MAX_TRACKS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  nntf_pkg::t_cmd                       i_cmd,
    output nntf_pkg::t_sts                       o_sts,
    input  logic [nntf_pkg::GATE_W-1:0]          i_gate,
    input  logic [nntf_pkg::HITS_W-1:0]          i_hits_to_confirm,
    input  logic [nntf_pkg::ALLOW_W-1:0]         i_misses_allowed,
    input  logic                                 i_mode,
    input  logic                                 i_point_valid,
    input  logic signed [nntf_pkg::COORD_W-1:0]  i_east,
    input  logic signed [nntf_pkg::COORD_W-1:0]  i_north,
    input  logic                                 i_frame_last,
    input  logic                                 i_out_ready,
    output logic                                 o_out_vld,
    output logic                                 o_out_valid,
    output logic signed [nntf_pkg::COORD_W-1:0]  o_out_east,
    output logic signed [nntf_pkg::COORD_W-1:0]  o_out_north,
    output logic                                 o_out_last,
    output logic                                 o_table_overflow
);
    import nntf_pkg::*;

    localparam int AW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int CW = $clog2(MAX_TRACKS + 1);

    t_trk r_mem [MAX_TRACKS];
    t_trk r_rd;

    logic                       r_mode, r_pval, r_flast;
    logic signed [COORD_W-1:0]  r_pe, r_pn, r_pcx, r_pcy, r_ecx, r_ecy;
    logic [GATE2_W-1:0]         r_g2;
    logic [CW-1:0]              r_cnt, r_idx, r_kept;
    logic                       r_open, r_ovf;
    logic signed [COORD_W:0]    r_de, r_dn;
    logic                       r_cell_ok;
    logic [2*COORD_W-1:0]       r_de2, r_dn2;
    logic                       r_bvld;
    logic [AW-1:0]              r_bidx;
    logic [DIST_W-1:0]          r_bd;
    logic signed [COORD_W-1:0]  r_bcx, r_bcy;
    logic [HITS_W-1:0]          r_bhits;
    logic                       r_bconf;
    logic                       r_pend_vld;
    logic signed [COORD_W-1:0]  r_pend_e, r_pend_n;
    logic                       r_out_vld, r_out_valid, r_out_last, r_out_ovf;
    logic signed [COORD_W-1:0]  r_out_e, r_out_n;

    logic [GATE_W-1:0]          w_gate;
    logic [HITS_W-1:0]          w_need;
    logic signed [COORD_W-1:0]  w_div_in, w_quo;
    logic                       w_div_done;
    logic signed [COORD_W:0]    w_dcx, w_dcy;
    logic signed [2*COORD_W+1:0] w_pe2, w_pn2;
    logic [DIST_W-1:0]          w_d2;
    logic                       w_hit, w_better;
    logic [HITS_W-1:0]          w_bhits_n;
    logic [MISS_W-1:0]          w_miss_n;
    logic                       w_keep, w_emit, w_out_free;
    logic                       w_we;
    logic [AW-1:0]              w_waddr;
    t_trk                       w_wdata;

    assign w_gate = (i_gate == '0) ? GATE_W'(1) : i_gate;
    assign w_need = (i_hits_to_confirm == '0) ? HITS_W'(1) : i_hits_to_confirm;

    always_comb begin
        case (i_cmd.div_src)
            DS_ENT_EAST:  w_div_in = r_rd.east;
            DS_ENT_NORTH: w_div_in = r_rd.north;
            DS_PT_EAST:   w_div_in = r_pe;
            DS_PT_NORTH:  w_div_in = r_pn;
            default:      w_div_in = r_pe;
        endcase
    end

    nntf_fdiv u_fdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_div_in),
        .i_divisor  (w_gate),
        .o_done     (w_div_done),
        .o_quo      (w_quo)
    );

    // scan arithmetic
    assign w_dcx = {r_rd.cell_x[COORD_W-1], r_rd.cell_x} - {r_pcx[COORD_W-1], r_pcx};
    assign w_dcy = {r_rd.cell_y[COORD_W-1], r_rd.cell_y} - {r_pcy[COORD_W-1], r_pcy};
    assign w_pe2 = r_de * r_de;
    assign w_pn2 = r_dn * r_dn;
    assign w_d2  = {1'b0, r_de2} + {1'b0, r_dn2};
    assign w_hit = r_cell_ok && (w_d2 <= DIST_W'(r_g2));
    assign w_better = !r_bvld || (w_d2 < r_bd) ||
                      ((w_d2 == r_bd) && ((r_rd.cell_y < r_bcy) ||
                       ((r_rd.cell_y == r_bcy) && (r_rd.cell_x < r_bcx))));

    assign w_bhits_n = (!r_bconf && (r_bhits < w_need)) ? r_bhits + 1'b1 : r_bhits;

    // frame end aging
    assign w_miss_n = (r_rd.misses < MISS_SAT) ? r_rd.misses + 1'b1 : r_rd.misses;
    assign w_keep   = r_rd.matched ||
                      (r_rd.confirmed && (w_miss_n <= MISS_W'(i_misses_allowed)));
    assign w_emit   = w_keep && r_rd.confirmed;
    assign w_out_free = !r_out_vld || i_out_ready;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx[AW-1:0];
        w_wdata = r_rd;
        if (i_cmd.fs_wr) begin
            w_we           = 1'b1;
            w_wdata.cell_x = r_ecx;
            w_wdata.cell_y = r_ecy;
            w_wdata.matched = 1'b0;
        end else if (i_cmd.commit) begin
            w_wdata.east    = r_pe;
            w_wdata.north   = r_pn;
            w_wdata.misses  = '0;
            w_wdata.matched = 1'b1;
            if (r_bvld) begin
                w_we              = 1'b1;
                w_waddr           = r_bidx;
                w_wdata.cell_x    = r_bcx;
                w_wdata.cell_y    = r_bcy;
                w_wdata.hits      = w_bhits_n;
                w_wdata.confirmed = r_bconf || (w_bhits_n >= w_need);
            end else begin
                w_we              = r_cnt < CW'(MAX_TRACKS);
                w_waddr           = r_cnt[AW-1:0];
                w_wdata.cell_x    = r_pcx;
                w_wdata.cell_y    = r_pcy;
                w_wdata.hits      = HITS_W'(1);
                w_wdata.confirmed = w_need <= HITS_W'(1);
            end
        end else if (i_cmd.cp_do) begin
            w_we    = w_keep;
            w_waddr = r_kept[AW-1:0];
            if (!r_rd.matched) begin
                w_wdata.misses = w_miss_n;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.mem_rd) begin
            r_rd <= r_mem[r_idx[AW-1:0]];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_open     <= 1'b0;
            r_ovf      <= 1'b0;
            r_out_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
            r_bvld     <= 1'b0;
            r_idx      <= '0;
            r_kept     <= '0;
        end else begin
            if (r_out_vld && i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cmd.clr_tbl) begin
                r_cnt  <= '0;
                r_ovf  <= 1'b0;
                r_open <= 1'b0;
            end
            if (i_cmd.open_set) begin
                r_open <= 1'b1;
            end
            if (i_cmd.sweep_clr) begin
                r_idx      <= '0;
                r_kept     <= '0;
                r_pend_vld <= 1'b0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.best_clr) begin
                r_bvld <= 1'b0;
            end else if (i_cmd.cmp && w_hit && w_better) begin
                r_bvld <= 1'b1;
            end
            if (i_cmd.commit && !r_bvld) begin
                if (r_cnt < CW'(MAX_TRACKS)) begin
                    r_cnt <= r_cnt + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.cp_do) begin
                if (w_keep) begin
                    r_kept <= r_kept + 1'b1;
                end
                if (w_emit) begin
                    r_pend_vld <= 1'b1;
                    if (r_pend_vld) begin
                        r_out_vld <= 1'b1;
                    end
                end
            end
            if (i_cmd.emit_final) begin
                r_out_vld <= 1'b1;
                r_cnt     <= r_kept;
                r_ovf     <= 1'b0;
                r_open    <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_mode  <= i_mode;
            r_pval  <= i_point_valid;
            r_flast <= i_frame_last;
            r_pe    <= i_east;
            r_pn    <= i_north;
        end
        if (i_cmd.div_cap) begin
            case (i_cmd.div_src)
                DS_ENT_EAST:  r_ecx <= w_quo;
                DS_ENT_NORTH: r_ecy <= w_quo;
                DS_PT_EAST:   r_pcx <= w_quo;
                DS_PT_NORTH:  r_pcy <= w_quo;
                default:      r_pcy <= w_quo;
            endcase
        end
        if (i_cmd.best_clr) begin
            r_g2 <= GATE2_W'(w_gate) * GATE2_W'(w_gate);
        end
        if (i_cmd.ev) begin
            r_cell_ok <= !r_rd.matched &&
                         ((w_dcx == '0) || (w_dcx == (COORD_W+1)'(1)) || (w_dcx == '1)) &&
                         ((w_dcy == '0) || (w_dcy == (COORD_W+1)'(1)) || (w_dcy == '1));
            r_de <= {r_rd.east[COORD_W-1], r_rd.east} - {r_pe[COORD_W-1], r_pe};
            r_dn <= {r_rd.north[COORD_W-1], r_rd.north} - {r_pn[COORD_W-1], r_pn};
        end
        if (i_cmd.sq) begin
            r_de2 <= w_pe2[2*COORD_W-1:0];
            r_dn2 <= w_pn2[2*COORD_W-1:0];
        end
        if (i_cmd.cmp && w_hit && w_better) begin
            r_bidx  <= r_idx[AW-1:0];
            r_bd    <= w_d2;
            r_bcx   <= r_rd.cell_x;
            r_bcy   <= r_rd.cell_y;
            r_bhits <= r_rd.hits;
            r_bconf <= r_rd.confirmed;
        end
        if (i_cmd.cp_do && w_emit) begin
            r_pend_e <= r_rd.east;
            r_pend_n <= r_rd.north;
            if (r_pend_vld) begin
                r_out_valid <= 1'b1;
                r_out_e     <= r_pend_e;
                r_out_n     <= r_pend_n;
                r_out_last  <= 1'b0;
                r_out_ovf   <= r_ovf;
            end
        end
        if (i_cmd.emit_final) begin
            r_out_valid <= r_pend_vld;
            r_out_e     <= r_pend_vld ? r_pend_e : '0;
            r_out_n     <= r_pend_vld ? r_pend_n : '0;
            r_out_last  <= 1'b1;
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_sts.idx_lt       = r_idx < r_cnt;
    assign o_sts.div_done     = w_div_done;
    assign o_sts.open         = r_open;
    assign o_sts.mode         = r_mode;
    assign o_sts.pval         = r_pval;
    assign o_sts.flast        = r_flast;
    assign o_sts.out_free     = w_out_free;
    assign o_sts.cp_need_push = w_emit && r_pend_vld;

    assign o_out_vld        = r_out_vld;
    assign o_out_valid      = r_out_valid;
    assign o_out_east       = r_out_e;
    assign o_out_north      = r_out_n;
    assign o_out_last       = r_out_last;
    assign o_table_overflow = r_out_ovf;

endmodule

// ===== sv/nearest_neighbor_track_filter.sv =====
// A valid point divides both coordinates and then scans every stored track; an invalid one
// skips both; the first word of a frame also recomputes the cells of every stored track.
// These steps use the shared divider and walk the track memory one track at a time.
// A frame's last word also compacts the table track by track and may wait on m_tready.
// Throughput: one word at a time. Reset empties the table and loads default registers.
module nearest_neighbor_track_filter #(
    parameter int MAX_TRACKS = nntf_pkg::MAX_TRACKS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [47:0]                         s_tdata,   // east, north
    input  logic [1:0]                          s_tuser,   // mode, point_valid
    input  logic                                s_tlast,   // frame_last
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [47:0]                         m_tdata,   // out_east, out_north
    output logic [1:0]                          m_tuser,   // out_valid, table_overflow
    output logic                                m_tlast,   // out_last
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [nntf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [nntf_pkg::GATE_W-1:0]         i_cfg_data
);
    import nntf_pkg::*;

    logic [GATE_W-1:0]  r_gate;
    logic [HITS_W-1:0]  r_hits;
    logic [ALLOW_W-1:0] r_allow;
    t_cmd               w_cmd;
    t_sts               w_sts;
    logic               w_out_valid, w_out_last, w_ovf;
    logic signed [COORD_W-1:0] w_out_e, w_out_n;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate  <= GATE_RST;
            r_hits  <= HITS_RST;
            r_allow <= ALLOW_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_GATE:  r_gate  <= i_cfg_data;
                REG_HITS:  r_hits  <= i_cfg_data[HITS_W-1:0];
                REG_ALLOW: r_allow <= i_cfg_data[ALLOW_W-1:0];
                default:   r_gate  <= r_gate;
            endcase
        end
    end

    nntf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    nntf_dp #(
        .MAX_TRACKS (MAX_TRACKS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_gate            (r_gate),
        .i_hits_to_confirm (r_hits),
        .i_misses_allowed  (r_allow),
        .i_mode            (s_tuser[0]),
        .i_point_valid     (s_tuser[1]),
        .i_east            (s_tdata[23:0]),
        .i_north           (s_tdata[47:24]),
        .i_frame_last      (s_tlast),
        .i_out_ready       (m_tready),
        .o_out_vld         (m_tvalid),
        .o_out_valid       (w_out_valid),
        .o_out_east        (w_out_e),
        .o_out_north       (w_out_n),
        .o_out_last        (w_out_last),
        .o_table_overflow  (w_ovf)
    );

    assign m_tdata = {w_out_n, w_out_e};
    assign m_tuser = {w_ovf, w_out_valid};
    assign m_tlast = w_out_last;

endmodule

// ===== tb/track_result_checker.sv =====
// Checker: predicts the filter's confirmed points from the accepted words and compares them.
`timescale 1ns / 1ps
module track_result_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [47:0]                    i_s_tdata,   // east, north
    input  logic [1:0]                     i_s_tuser,   // mode, point_valid
    input  logic                           i_s_tlast,   // frame_last
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [47:0]                    i_m_tdata,   // out_east, out_north
    input  logic [1:0]                     i_m_tuser,   // out_valid, table_overflow
    input  logic                           i_m_tlast,   // out_last
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [nntf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nntf_pkg::GATE_W-1:0]    i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    import nntf_pkg::*;

    localparam int NTRK = MAX_TRACKS_DEF;

    typedef struct {
        logic                      pt_valid;
        logic signed [COORD_W-1:0] east;
        logic signed [COORD_W-1:0] north;
        logic                      last;
        logic                      overflow;
    } t_track_point;

    t_track_point pending_points[$];

    logic [GATE_W-1:0]  gate_reg;
    logic [HITS_W-1:0]  hits_reg;
    logic [ALLOW_W-1:0] allow_reg;

    longint      trk_e [NTRK];
    longint      trk_n [NTRK];
    longint      trk_cx[NTRK];
    longint      trk_cy[NTRK];
    int unsigned trk_h [NTRK];
    int unsigned trk_m [NTRK];
    bit          trk_c [NTRK];
    bit          trk_mt[NTRK];
    int          n_tracks;
    bit          dropped;
    bit          frame_open;

    function automatic longint floor_cell(longint a, longint g);
        longint q;
        q = a / g;
        if ((a % g) != 0 && a < 0) q = q - 1;
        return q;
    endfunction

    function automatic longint abs64(longint a);
        return (a < 0) ? -a : a;
    endfunction

    task automatic track_word(input logic [47:0] data, input logic [1:0] user,
                              input logic flast);
        longint       gate, pe, pn, cx, cy, de, dn, d2, g2, bd;
        int unsigned  need;
        int           best, kept, nres;
        t_track_point tp;
        gate = (gate_reg == 0) ? 1 : longint'(gate_reg);
        need = (hits_reg == 0) ? 1 : int'(hits_reg);
        if (user[0]) begin
            n_tracks   = 0;
            dropped    = 0;
            frame_open = 0;
            return;
        end
        if (!frame_open) begin
            for (int i = 0; i < n_tracks; i++) begin
                trk_cx[i] = floor_cell(trk_e[i], gate);
                trk_cy[i] = floor_cell(trk_n[i], gate);
                trk_mt[i] = 0;
            end
            frame_open = 1;
        end
        if (user[1]) begin
            pe   = longint'($signed(data[23:0]));
            pn   = longint'($signed(data[47:24]));
            cx   = floor_cell(pe, gate);
            cy   = floor_cell(pn, gate);
            g2   = gate * gate;
            bd   = 0;
            best = -1;
            for (int i = 0; i < n_tracks; i++) begin
                if (trk_mt[i]) continue;
                if (abs64(trk_cx[i] - cx) > 1 || abs64(trk_cy[i] - cy) > 1) continue;
                de = trk_e[i] - pe;
                dn = trk_n[i] - pn;
                d2 = de * de + dn * dn;
                if (d2 > g2) continue;
                if (best < 0 || d2 < bd || (d2 == bd && (trk_cy[i] < trk_cy[best] ||
                    (trk_cy[i] == trk_cy[best] && trk_cx[i] < trk_cx[best])))) begin
                    best = i;
                    bd   = d2;
                end
            end
            if (best < 0) begin
                if (n_tracks < NTRK) begin
                    trk_e[n_tracks]  = pe;
                    trk_n[n_tracks]  = pn;
                    trk_cx[n_tracks] = cx;
                    trk_cy[n_tracks] = cy;
                    trk_h[n_tracks]  = 1;
                    trk_m[n_tracks]  = 0;
                    trk_c[n_tracks]  = (need <= 1);
                    trk_mt[n_tracks] = 1;
                    n_tracks++;
                end else begin
                    dropped = 1;
                end
            end else begin
                trk_mt[best] = 1;
                trk_e[best]  = pe;
                trk_n[best]  = pn;
                trk_m[best]  = 0;
                if (!trk_c[best]) begin
                    if (trk_h[best] < need) trk_h[best]++;
                    trk_c[best] = (trk_h[best] >= need);
                end
            end
        end
        if (!flast) return;
        kept = 0;
        nres = 0;
        for (int i = 0; i < n_tracks; i++) begin
            if (!trk_mt[i]) begin
                if (!trk_c[i]) continue;
                if (trk_m[i] < int'(MISS_SAT)) trk_m[i]++;
                if (trk_m[i] > int'(allow_reg)) continue;
            end
            trk_e[kept]  = trk_e[i];
            trk_n[kept]  = trk_n[i];
            trk_cx[kept] = trk_cx[i];
            trk_cy[kept] = trk_cy[i];
            trk_h[kept]  = trk_h[i];
            trk_m[kept]  = trk_m[i];
            trk_c[kept]  = trk_c[i];
            trk_mt[kept] = trk_mt[i];
            if (trk_c[kept]) begin
                tp.pt_valid = 1;
                tp.east     = trk_e[kept][23:0];
                tp.north    = trk_n[kept][23:0];
                tp.last     = 0;
                tp.overflow = dropped;
                pending_points.insert(pending_points.size(), tp);
                nres++;
            end
            kept++;
        end
        n_tracks = kept;
        if (nres == 0) begin
            tp.pt_valid = 0;
            tp.east     = '0;
            tp.north    = '0;
            tp.last     = 1;
            tp.overflow = dropped;
            pending_points.insert(pending_points.size(), tp);
        end else begin
            pending_points[pending_points.size()-1].last = 1;
        end
        dropped    = 0;
        frame_open = 0;
    endtask

    always @(posedge i_clk) begin
        t_track_point want;
        if (!i_rst_n) begin
            gate_reg     <= GATE_RST;
            hits_reg     <= HITS_RST;
            allow_reg    <= ALLOW_RST;
            o_fail_count <= 0;
            n_tracks     = 0;
            dropped      = 0;
            frame_open   = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_GATE:  gate_reg  <= i_cfg_data;
                    REG_HITS:  hits_reg  <= i_cfg_data[HITS_W-1:0];
                    REG_ALLOW: allow_reg <= i_cfg_data[ALLOW_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) track_word(i_s_tdata, i_s_tuser, i_s_tlast);
            if (i_m_tvalid && i_m_tready) begin
                if (pending_points.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result word: data %h user %b last %b",
                                 i_m_tdata, i_m_tuser, i_m_tlast);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = pending_points.pop_front();
                    if (i_m_tuser[0] !== want.pt_valid || i_m_tuser[1] !== want.overflow ||
                        i_m_tdata[23:0] !== want.east || i_m_tdata[47:24] !== want.north ||
                        i_m_tlast !== want.last) begin
                        if (o_fail_count < 10)
                            $display("mismatch: exp v%b e%h n%h l%b o%b got v%b e%h n%h l%b o%b",
                                     want.pt_valid, want.east, want.north, want.last,
                                     want.overflow, i_m_tuser[0], i_m_tdata[23:0],
                                     i_m_tdata[47:24], i_m_tlast, i_m_tuser[1]);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= pending_points.size();
    end
endmodule

// ===== tb/nearest_neighbor_track_filter_tb.sv =====
// Testbench top: drives frames of points and register writes, then reports the verdict.
`timescale 1ns / 1ps
module nearest_neighbor_track_filter_tb;
    import nntf_pkg::*;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [47:0]          s_tdata = '0;
    logic [1:0]           s_tuser = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [47:0]          m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [GATE_W-1:0]    i_cfg_data = '0;
    int                   fail_count;
    int                   pending;
    int                   words_sent = 0;
    int                   stall_left = 0;
    int                   calm_left = 0;
    longint               gate_now = 256;
    longint               pool_e[8];
    longint               pool_n[8];

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    nearest_neighbor_track_filter i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    track_result_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_s_tuser(s_tuser), .i_s_tlast(s_tlast),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_m_tuser(m_tuser), .i_m_tlast(m_tlast),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver back-pressure: short random stalls, rare long ones, calm stretches.
    always @(posedge i_clk) begin
        int r;
        r = $urandom_range(0, 999);
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (calm_left > 0) begin
            m_tready  <= 1'b1;
            calm_left <= calm_left - 1;
        end else if (r < 10) begin
            stall_left <= $urandom_range(20, 80);
            m_tready   <= 1'b0;
        end else if (r < 20) begin
            calm_left <= $urandom_range(100, 400);
            m_tready  <= 1'b1;
        end else begin
            m_tready <= (r >= 250);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [23:0] clamp24(longint v);
        if (v > 8388607) return 24'h7FFFFF;
        if (v < -8388608) return 24'h800000;
        return v[23:0];
    endfunction

    task automatic send_word(input logic mode, input logic pv, input logic [23:0] e,
                             input logic [23:0] n, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {n, e};
        s_tuser  <= {pv, mode};
        s_tlast  <= last;
        do @(posedge i_clk); while (!s_tready);
        words_sent++;
    endtask

    task automatic send_point(input longint e, input longint n, input logic last);
        send_word(1'b0, 1'b1, clamp24(e), clamp24(n), last);
    endtask

    task automatic send_clear();
        send_word(1'b1, 1'($urandom_range(0, 1)), 24'($urandom), 24'($urandom),
                  1'($urandom_range(0, 1)));
    endtask

    // Drop valid, then hold until every result is out and the block has settled.
    task automatic wait_idle();
        @(posedge i_clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GATE_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_GATE) gate_now = (val == 0) ? 1 : longint'(val);
    endtask

    task automatic load_settings(input logic [GATE_W-1:0] g, input logic [7:0] h,
                                 input logic [15:0] m);
        write_reg(REG_GATE, g);
        write_reg(REG_HITS, {15'd0, h});
        write_reg(REG_ALLOW, {7'd0, m});
    endtask

    task automatic new_pool();
        longint span;
        span = gate_now * 20;
        if (span > 8388607) span = 8388607;
        foreach (pool_e[i]) begin
            pool_e[i] = longint'($urandom_range(0, 2 * span)) - span;
            pool_n[i] = longint'($urandom_range(0, 2 * span)) - span;
        end
    endtask

    // Random frame: mostly points near the pool, some noise and broken frames.
    task automatic random_frame();
        int     len, r, k;
        longint j;
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            k = $urandom_range(0, 7);
            j = gate_now / 2 + 1;
            if (r < 70)
                send_point(pool_e[k] + longint'($urandom_range(0, 2 * j)) - j,
                           pool_n[k] + longint'($urandom_range(0, 2 * j)) - j,
                           i == len - 1);
            else if (r < 85)
                send_word(1'b0, 1'b1, 24'($urandom), 24'($urandom), i == len - 1);
            else if (r < 95)
                send_word(1'b0, 1'b0, 24'($urandom), 24'($urandom), i == len - 1);
            else begin
                send_clear();
                return;
            end
        end
    endtask

    initial begin
        int phase;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: default registers
        send_clear();
        send_point(0, 0, 1'b1);
        send_point(10, -10, 1'b1);
        send_point(20, 5, 1'b1);
        send_point(30, 0, 1'b0);
        send_word(1'b0, 1'b0, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
        send_point(-8388608, -8388608, 1'b0);
        send_point(8388607, 8388607, 1'b1);
        // tie: equal distance from two tracks in different cells
        send_clear();
        send_point(-100, 0, 1'b0);
        send_point(100, 0, 1'b1);
        send_point(0, 0, 1'b1);
        wait_idle();

        // directed: instant confirmation, no misses allowed
        load_settings(23'd1, 8'd1, 16'd0);
        send_point(5, 5, 1'b0);
        send_point(6, 5, 1'b1);
        send_word(1'b0, 1'b0, '0, '0, 1'b1);
        send_word(1'b0, 1'b0, '0, '0, 1'b1);
        wait_idle();

        // full table: drop points past capacity, then an empty frame retires every track
        send_clear();
        for (int i = 0; i < 66; i++) send_point(longint'(i) * 1000 - 30000, 7, 1'b0);
        send_point(-8388608, 8388607, 1'b1);
        send_word(1'b0, 1'b0, '0, '0, 1'b1);
        wait_idle();

        // zero values act as one
        load_settings(23'd0, 8'd0, 16'd65535);
        send_clear();
        send_point(3, 3, 1'b1);
        send_point(4, 3, 1'b1);
        wait_idle();

        phase = 0;
        while (words_sent < 120) begin
            case (phase % 6)
                0: load_settings(23'd256, 8'd3, 16'd5);
                1: load_settings(23'd8388607, 8'd255, 16'd65535);
                2: load_settings(23'd1, 8'd1, 16'd0);
                3: load_settings(23'($urandom_range(1, 4096)), 8'($urandom_range(1, 4)),
                                 16'($urandom_range(0, 3)));
                4: load_settings(23'($urandom_range(1, 8388607)), 8'($urandom_range(1, 255)),
                                 16'($urandom_range(0, 65535)));
                default: load_settings(23'($urandom_range(16, 2000)), 8'd2, 16'd1);
            endcase
            new_pool();
            if ($urandom_range(0, 1)) send_clear();
            repeat ($urandom_range(2, 4)) random_frame();
            send_point(pool_e[0], pool_n[0], 1'b1);
            wait_idle();
            phase++;
        end

        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #40ms;
        $display("simulation failed");
        $finish;
    end
endmodule
